// ----- rtl/core/rpu_pkg.sv -----
// Shared types and constants of the RMSProp parameter update engine.
`default_nettype none
package rpu_pkg;

	localparam int XW     = 8;   // channel index width
	localparam int GW     = 32;  // Q16.16 gradient and parameter width
	localparam int IW     = 24;  // iteration count width
	localparam int RHO_W  = 16;  // Q0.16 forget factor width
	localparam int G2_W   = 47;  // squared gradient, Q31.16 without saturation
	localparam int DEN_W  = 56;  // 1 + decay*iter in Q32.24
	localparam int Q_W    = 32;  // quotient bits of both dividers
	localparam int SQ_QW  = 25;  // root bits
	localparam int SQ_RW  = 27;  // root remainder bits
	localparam int SQ_VW  = 2 * SQ_QW; // radicand bits, two per root bit
	localparam int DV_W   = SQ_QW + 8; // step divisor, root scaled by 256

	localparam int ELEM_CODES = 1 << XW;

	localparam logic [RHO_W:0]   ONE_Q16     = 17'h1_0000;
	localparam logic [DEN_W-1:0] ONE_Q24     = 56'h100_0000;
	localparam logic [DV_W-1:0]  MIN_DIVISOR = 33'd256;
	localparam logic [GW-1:0]    S32_MAX     = 32'h7FFF_FFFF;
	localparam logic [GW-1:0]    S32_MIN     = 32'h8000_0000;
	localparam logic [GW-1:0]    U32_MAX     = 32'hFFFF_FFFF;

	localparam logic [31:0] BASE_RATE_RST     = 32'd16777;
	localparam logic [31:0] RATE_DECAY_RST    = 32'd0;
	localparam logic [31:0] STABILIZER_RST    = 32'd1;
	localparam logic [15:0] FORGET_FACTOR_RST = 16'd58982;

	typedef enum logic [1:0] {
		REG_BASE_RATE,
		REG_RATE_DECAY,
		REG_STABILIZER,
		REG_FORGET_FACTOR
	} cfg_reg_t;

	// Per-element data that rides along the pipeline.
	typedef struct packed {
		logic          sel;
		logic [XW-1:0] idx;
		logic [GW-1:0] param;
		logic          neg;
		logic [GW-1:0] gmag;
		logic [GW-1:0] cache;
	} side_t;

	// Front end result handed to the divider and root chains.
	typedef struct packed {
		logic             vld;
		side_t            sd;
		logic [DEN_W-1:0] den;
	} front_t;

endpackage
`default_nettype wire

// ----- rtl/core/rpu_div_cell.sv -----
// One restoring division step: a quotient bit per cell.
`default_nettype none
module rpu_div_cell #(
	parameter int DW = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [DW-1:0]          r_in,
	input  logic [DW-1:0]          d_in,
	input  logic [rpu_pkg::Q_W-1:0] n_in,
	input  logic [rpu_pkg::Q_W-1:0] q_in,
	output logic [DW-1:0]          r_out,
	output logic [DW-1:0]          d_out,
	output logic [rpu_pkg::Q_W-1:0] n_out,
	output logic [rpu_pkg::Q_W-1:0] q_out
);
	import rpu_pkg::*;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {r_in, n_in[Q_W-1]};
	assign ge    = trial >= {1'b0, d_in};
	assign diff  = trial - {1'b0, d_in};

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= ge ? diff[DW-1:0] : trial[DW-1:0];
			d_out <= d_in;
			n_out <= {n_in[Q_W-2:0], 1'b0};
			q_out <= {q_in[Q_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rpu_sqrt_cell.sv -----
// One digit step of the integer square root: a root bit per cell.
`default_nettype none
module rpu_sqrt_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rpu_pkg::SQ_RW-1:0] r_in,
	input  logic [rpu_pkg::SQ_QW-1:0] q_in,
	input  logic [rpu_pkg::SQ_VW-1:0] v_in,
	output logic [rpu_pkg::SQ_RW-1:0] r_out,
	output logic [rpu_pkg::SQ_QW-1:0] q_out,
	output logic [rpu_pkg::SQ_VW-1:0] v_out
);
	import rpu_pkg::*;

	logic [SQ_RW+1:0] rem;
	logic [SQ_RW+1:0] trial;
	logic [SQ_RW+1:0] diff;
	logic             ge;

	assign rem   = {r_in, v_in[SQ_VW-1 -: 2]};
	assign trial = (SQ_RW + 2)'({q_in, 2'b01});
	assign ge    = rem >= trial;
	assign diff  = rem - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			r_out <= ge ? diff[SQ_RW-1:0] : rem[SQ_RW-1:0];
			q_out <= {q_in[SQ_QW-2:0], ge};
			v_out <= {v_in[SQ_VW-3:0], 2'b00};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/rpu_front.sv -----
// Cache memory, clearing pass, squared gradient, rate denominator and cache update with forwarding.
`default_nettype none
module rpu_front #(
	parameter int CHANNELS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      acc,
	input  logic                      in_sel,
	input  logic [rpu_pkg::XW-1:0]    in_elem,
	input  logic [rpu_pkg::GW-1:0]    in_grad,
	input  logic [rpu_pkg::GW-1:0]    in_param,
	input  logic [rpu_pkg::IW-1:0]    in_iter,
	input  logic [rpu_pkg::RHO_W-1:0] rho,
	input  logic [31:0]               decay,
	output rpu_pkg::front_t           fr,
	output logic                      busy
);
	import rpu_pkg::*;

	localparam int DEPTH = 2 * CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CW-1:0]    chan_lut [ELEM_CODES];
	logic [GW-1:0]    mem [DEPTH];
	logic [CNT_W-1:0] clr_q;
	logic [AW-1:0]    addr_in;
	side_t            sd_in;

	logic v_s1, v_s2, v_s3, v_s4;
	side_t sd_s1, sd_s2, sd_s3, sd_s4;
	side_t sd_cn;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	logic [IW-1:0] iter_s1;
	logic [GW-1:0] rd_q, fwd_q, cache_s2, cache_s3;
	logic          hit_q;
	logic [G2_W-1:0] g2_s2, g2t_s3;
	logic [DEN_W-1:0] prd_s2, den_s3, den_s4;

	logic [GW-1:0]    cache_s1;
	logic [63:0]      gsq, g2p;
	logic [RHO_W:0]   omr;
	logic [47:0]      cr, csum;
	logic [GW-1:0]    cnew;
	logic             wr;

	// Channel fold for indexes at or above the channel count.
	for (genvar i = 0; i < ELEM_CODES; i++) begin : g_lut
		assign chan_lut[i] = CW'(i % CHANNELS);
	end

	assign addr_in = AW'(chan_lut[in_elem]) + (in_sel ? AW'(CHANNELS) : AW'(0));

	always_comb begin
		sd_in.sel   = in_sel;
		sd_in.idx   = in_elem;
		sd_in.param = in_param;
		sd_in.neg   = in_grad[GW-1];
		sd_in.gmag  = in_grad[GW-1] ? (~in_grad + 1'b1) : in_grad;
		sd_in.cache = '0;
	end

	assign busy = clr_q < CNT_W'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Cache update of the item in stage 3; its result forwards to younger items.
	assign cache_s1 = hit_q ? fwd_q : rd_q;
	assign omr      = ONE_Q16 - {1'b0, rho};
	assign gsq      = 64'(sd_s1.gmag) * 64'(sd_s1.gmag);
	assign g2p      = 64'(g2_s2) * 64'(omr);
	assign cr       = 48'(cache_s3) * 48'(rho);
	assign csum     = 48'(cr[47:16]) + 48'(g2t_s3);
	assign cnew     = (csum[47:GW] != '0) ? U32_MAX : csum[GW-1:0];
	assign wr       = en && v_s3;

	always_comb begin
		sd_cn       = sd_s3;
		sd_cn.cache = cnew;
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (wr) begin
			mem[addr_s3] <= cnew;
		end
		if (en) begin
			rd_q <= mem[addr_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1   <= sd_in;
			addr_s1 <= addr_in;
			iter_s1 <= in_iter;
			hit_q   <= wr && (addr_s3 == addr_in);
			fwd_q   <= cnew;

			sd_s2    <= sd_s1;
			addr_s2  <= addr_s1;
			g2_s2    <= gsq[62:16];
			prd_s2   <= 56'(decay) * 56'(iter_s1);
			cache_s2 <= (wr && addr_s3 == addr_s1) ? cnew : cache_s1;

			sd_s3    <= sd_s2;
			addr_s3  <= addr_s2;
			g2t_s3   <= g2p[62:16];
			den_s3   <= ONE_Q24 + prd_s2;
			cache_s3 <= (wr && addr_s3 == addr_s2) ? cnew : cache_s2;

			sd_s4  <= sd_cn;
			den_s4 <= den_s3;
		end
	end

	assign fr.vld = v_s4;
	assign fr.sd  = sd_s4;
	assign fr.den = den_s4;

endmodule
`default_nettype wire

// ----- rtl/core/rmsprop_param_update.sv -----
// Top level of the RMSProp parameter update engine.
//
// Elements arrive on the slave stream, one transaction per element, and the
// updated parameter and cache entry leave on the master stream in the same
// order, one transaction per element. Registers are written on the cfg
// channel, which is always ready; write them only while no element is in
// flight. The block takes one element every cycle unless the receiver stalls
// or the cache is being cleared. From input transaction to output valid, an
// element passes through the cache read and update stages, a 32-cell divider
// for the decayed rate running beside a 25-cell square root, a multiply stage,
// a second 32-cell divider for the step, and the output register. The cache
// update is the only loop across elements; it closes through forwarding, so
// repeated indexes cost nothing. After reset the cache memory is cleared one
// entry per cycle, all 2*CHANNELS entries (512 at the default), while s_tready
// is low. When the receiver stalls, the output register holds its transaction
// and the whole pipeline stops, except that an empty slot ahead of the output
// is still closed up, so new elements keep entering until that slot is filled.
`default_nettype none
module rmsprop_param_update #(
	parameter int CHANNELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // elem_index[7:0], gradient[39:8], param_in[71:40],
	                               // iteration[95:72]
	input  logic        s_tuser,   // tensor_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // index_out[7:0], param_out[39:8], cache_out[71:40]
	output logic        m_tuser,   // tensor_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import rpu_pkg::*;

	logic [31:0] base_rate_q, rate_decay_q, stabilizer_q;
	logic [15:0] forget_factor_q;

	logic   en, acc, front_busy;
	front_t fr;

	// Rate divider and root chain.
	logic [DEN_W-1:0] l_r [0:Q_W];
	logic [DEN_W-1:0] l_d [0:Q_W];
	logic [Q_W-1:0]   l_n [0:Q_W];
	logic [Q_W-1:0]   l_q [0:Q_W];
	logic [SQ_RW-1:0] s_r [0:SQ_QW];
	logic [SQ_VW-1:0] s_v [0:SQ_QW];
	logic [SQ_QW-1:0] rt  [0:Q_W];
	logic             v1  [0:Q_W];
	side_t            sd1 [0:Q_W];
	logic [GW:0]      rsum;

	// Multiply stage.
	logic            v_m;
	side_t           sd_m;
	logic [63:0]     prod_m;
	logic [DV_W-1:0] dv_m;
	logic            ovf;

	// Step divider chain.
	logic [DV_W-1:0] c_r [0:Q_W];
	logic [DV_W-1:0] c_d [0:Q_W];
	logic [Q_W-1:0]  c_n [0:Q_W];
	logic [Q_W-1:0]  c_q [0:Q_W];
	logic            v2  [0:Q_W];
	logic            ov2 [0:Q_W];
	side_t           sd2 [0:Q_W];

	logic [GW+1:0] wide;
	logic [GW-1:0] res;

	logic          m_tvalid_q, out_sel_q;
	logic [XW-1:0] out_idx_q;
	logic [GW-1:0] out_par_q, out_cache_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rate_q     <= BASE_RATE_RST;
			rate_decay_q    <= RATE_DECAY_RST;
			stabilizer_q    <= STABILIZER_RST;
			forget_factor_q <= FORGET_FACTOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BASE_RATE:     base_rate_q     <= cfg_data;
				REG_RATE_DECAY:    rate_decay_q    <= cfg_data;
				REG_STABILIZER:    stabilizer_q    <= cfg_data;
				REG_FORGET_FACTOR: forget_factor_q <= cfg_data[15:0];
				default:           base_rate_q     <= base_rate_q;
			endcase
		end
	end

	// The pipeline moves as a whole; it may also move while the output holds
	// a stalled transaction, as long as the last stage is empty.
	assign en       = m_tready || !m_tvalid_q || !v2[Q_W];
	assign s_tready = en && !front_busy;
	assign acc      = s_tvalid && s_tready;

	rpu_front #(.CHANNELS(CHANNELS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.acc      (acc),
		.in_sel   (s_tuser),
		.in_elem  (s_tdata[7:0]),
		.in_grad  (s_tdata[39:8]),
		.in_param (s_tdata[71:40]),
		.in_iter  (s_tdata[95:72]),
		.rho      (forget_factor_q),
		.decay    (rate_decay_q),
		.fr       (fr),
		.busy     (front_busy)
	);

	// The decayed rate is lr*2^24 / den. The top 24 bits of lr*2^24 start as
	// the partial remainder; the other 32 bits shift in one per cell.
	assign rsum   = (GW + 1)'(fr.sd.cache) + (GW + 1)'(stabilizer_q);
	assign l_r[0] = DEN_W'(base_rate_q[31:8]);
	assign l_d[0] = fr.den;
	assign l_n[0] = {base_rate_q[7:0], 24'b0};
	assign l_q[0] = '0;
	assign s_r[0] = '0;
	assign s_v[0] = {1'b0, rsum, 16'b0};
	assign rt[0]  = '0;
	assign v1[0]  = fr.vld;
	assign sd1[0] = fr.sd;

	for (genvar k = 0; k < Q_W; k++) begin : g_chain1
		rpu_div_cell #(.DW(DEN_W)) u_div (
			.clk   (clk),
			.en    (en),
			.r_in  (l_r[k]),
			.d_in  (l_d[k]),
			.n_in  (l_n[k]),
			.q_in  (l_q[k]),
			.r_out (l_r[k+1]),
			.d_out (l_d[k+1]),
			.n_out (l_n[k+1]),
			.q_out (l_q[k+1])
		);

		if (k < SQ_QW) begin : g_root
			rpu_sqrt_cell u_sqrt (
				.clk   (clk),
				.en    (en),
				.r_in  (s_r[k]),
				.q_in  (rt[k]),
				.v_in  (s_v[k]),
				.r_out (s_r[k+1]),
				.q_out (rt[k+1]),
				.v_out (s_v[k+1])
			);
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rt[k+1] <= rt[k];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1[k+1] <= 1'b0;
			end else if (en) begin
				v1[k+1] <= v1[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd1[k+1] <= sd1[k];
			end
		end
	end

	// Rate times gradient magnitude; a zero root is taken as one LSB.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else if (en) begin
			v_m <= v1[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_m   <= sd1[Q_W];
			prod_m <= 64'(l_q[Q_W]) * 64'(sd1[Q_W].gmag);
			dv_m   <= (rt[Q_W] == '0) ? MIN_DIVISOR : {rt[Q_W], 8'b0};
		end
	end

	// A step of 2^32 or more saturates the result whatever the parameter, so
	// only 32 quotient bits are formed.
	assign ovf    = (DV_W'(prod_m[63:32]) >= dv_m);
	assign c_r[0] = ovf ? '0 : DV_W'(prod_m[63:32]);
	assign c_d[0] = dv_m;
	assign c_n[0] = prod_m[31:0];
	assign c_q[0] = '0;
	assign v2[0]  = v_m;
	assign ov2[0] = ovf;
	assign sd2[0] = sd_m;

	for (genvar k = 0; k < Q_W; k++) begin : g_chain2
		rpu_div_cell #(.DW(DV_W)) u_div (
			.clk   (clk),
			.en    (en),
			.r_in  (c_r[k]),
			.d_in  (c_d[k]),
			.n_in  (c_n[k]),
			.q_in  (c_q[k]),
			.r_out (c_r[k+1]),
			.d_out (c_d[k+1]),
			.n_out (c_n[k+1]),
			.q_out (c_q[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2[k+1] <= 1'b0;
			end else if (en) begin
				v2[k+1] <= v2[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ov2[k+1] <= ov2[k];
				sd2[k+1] <= sd2[k];
			end
		end
	end

	// Apply the step with the sign of the gradient and saturate.
	always_comb begin
		if (sd2[Q_W].neg) begin
			wide = {{2{sd2[Q_W].param[GW-1]}}, sd2[Q_W].param} + {2'b00, c_q[Q_W]};
		end else begin
			wide = {{2{sd2[Q_W].param[GW-1]}}, sd2[Q_W].param} - {2'b00, c_q[Q_W]};
		end
		if (ov2[Q_W]) begin
			res = sd2[Q_W].neg ? S32_MAX : S32_MIN;
		end else if (!wide[GW+1] && wide[GW:GW-1] != 2'b00) begin
			res = S32_MAX;
		end else if (wide[GW+1] && wide[GW:GW-1] != 2'b11) begin
			res = S32_MIN;
		end else begin
			res = wide[GW-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (m_tready || !m_tvalid_q) begin
			m_tvalid_q <= v2[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !m_tvalid_q) begin
			out_sel_q   <= sd2[Q_W].sel;
			out_idx_q   <= sd2[Q_W].idx;
			out_par_q   <= res;
			out_cache_q <= sd2[Q_W].cache;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_sel_q;
	assign m_tdata  = {out_cache_q, out_par_q, out_idx_q};

	// A stalled output with a full last stage must freeze the input side.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && v2[Q_W]) |-> !s_tready)
		else $error("input accepted while the pipeline is blocked");

	// A new output transaction comes only from a valid last stage.
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v2[Q_W]))
		else $error("output valid without a finished element");

	// No element enters while the cache is still being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(front_busy) && front_busy |-> !acc && !v1[0])
		else $error("element in flight during the clearing pass");

endmodule
`default_nettype wire

// ----- tb/tb_rmsprop_param_update.sv -----
// Self-checking testbench of the RMSProp parameter update engine.
`default_nettype none
module tb_rmsprop_param_update;
	import rpu_pkg::*;

	localparam int CH = 256;
	localparam int LATENCY = 70;
	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // elem_index, gradient, param_in, iteration
	logic        s_tuser = 1'b0; // tensor_sel
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // index_out, param_out, cache_out
	logic        m_tuser;        // tensor_out
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// One expected update leaving the engine.
	typedef struct packed {
		logic        sel;
		logic [7:0]  idx;
		logic [31:0] param;
		logic [31:0] cache;
	} update_t;

	update_t     pending_updates[$];
	logic [31:0] model_cache[2*CH];
	logic [31:0] lr, decay, eps;
	logic [15:0] rho;
	bit          failed = 1'b0;
	bit          sink_stall_on = 1'b1;
	bit          src_gaps_on = 1'b1;
	int          quiet_cycles = 0;

	rmsprop_param_update #(.CHANNELS(CH)) dut (.*);

	always #5 clk = ~clk;

	// Bitwise integer square root of a 64-bit radicand.
	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Computes one update and advances the model's cache.
	function automatic update_t rmsprop_update(logic sel, logic [7:0] idx, logic [31:0] g,
			logic [31:0] p, logic [23:0] iter);
		update_t u;
		logic [63:0] gmag, g2, cnew, den, lre, root, stp;
		logic signed [63:0] res;
		int addr;
		gmag = g[31] ? {32'd0, -g} : {32'd0, g};
		addr = sel * CH + idx % CH;
		g2 = (gmag * gmag) >> 16;
		cnew = ((64'(model_cache[addr]) * rho) >> 16) + ((g2 * (64'd65536 - rho)) >> 16);
		if (cnew > 64'hFFFF_FFFF) cnew = 64'hFFFF_FFFF;
		model_cache[addr] = cnew[31:0];
		den = 64'd16777216 + 64'(decay) * iter;
		lre = (64'(lr) << 24) / den;
		root = isqrt((cnew + eps) << 16);
		if (root == 0) root = 1;
		stp = (lre * gmag) / (root * 256);
		res = g[31] ? $signed(64'(signed'(p))) + $signed(stp)
			: $signed(64'(signed'(p))) - $signed(stp);
		if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
		if (res < -64'sh8000_0000) res = -64'sh8000_0000;
		u.sel = sel;
		u.idx = idx;
		u.param = res[31:0];
		u.cache = cnew[31:0];
		return u;
	endfunction

	// Drives one element and records its expected update on acceptance.
	task automatic send_element(logic sel, logic [7:0] idx, logic [31:0] g, logic [31:0] p,
			logic [23:0] iter);
		int gap;
		if (src_gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= sel;
		s_tdata <= {iter, p, g, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_updates.push_back(rmsprop_update(sel, idx, g, p, iter));
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_updates.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// Writes a register while the engine is idle, mirroring it in the model.
	task automatic write_reg(cfg_reg_t r, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (r)
			REG_BASE_RATE: begin
				lr = v;
			end
			REG_RATE_DECAY: begin
				decay = v;
			end
			REG_STABILIZER: begin
				eps = v;
			end
			default: begin
				rho = v[15:0];
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Sink side: random stall bursts, each transaction checked in order.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (sink_stall_on && $urandom_range(0, 6) == 0) begin
				stall = $urandom_range(1, 14);
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		update_t exp_u;
		if (m_tvalid && m_tready) begin
			if (pending_updates.size() == 0) begin
				$display("%0t: unexpected update %h/%h", $time, m_tuser, m_tdata);
				failed = 1'b1;
			end else begin
				exp_u = pending_updates.pop_front();
				if (m_tuser !== exp_u.sel) begin
					$display("%0t: tensor exp %h got %h", $time, exp_u.sel, m_tuser);
					failed = 1'b1;
				end
				if (m_tdata[7:0] !== exp_u.idx) begin
					$display("%0t: index exp %h got %h", $time, exp_u.idx, m_tdata[7:0]);
					failed = 1'b1;
				end
				if (m_tdata[39:8] !== exp_u.param) begin
					$display("%0t: param exp %h got %h", $time, exp_u.param, m_tdata[39:8]);
					failed = 1'b1;
				end
				if (m_tdata[71:40] !== exp_u.cache) begin
					$display("%0t: cache exp %h got %h", $time, exp_u.cache, m_tdata[71:40]);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| (!s_tvalid && pending_updates.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_random(int n, bit hot);
		logic [31:0] g;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: g = $urandom;
				1: g = $urandom_range(0, 32'h0003_FFFF) ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
				2: g = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: g = 32'($signed($urandom_range(0, 4096)) - 2048);
			endcase
			// Hot sets hammer a few elements so the cache builds up back to back.
			send_element(1'($urandom_range(0, 1)),
				hot ? 8'($urandom_range(0, 3)) : 8'($urandom),
				g, $urandom, 24'($urandom));
		end
	endtask

	task automatic test_directed();
		send_element(1'b0, 8'd0, 32'd0, 32'd0, 24'd0);
		send_element(1'b1, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
		send_element(1'b0, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0);
		send_element(1'b1, 8'h00, 32'h0001_0000, 32'h0000_0000, 24'd1);
		send_element(1'b1, 8'h00, 32'hFFFF_0000, 32'h1234_5678, 24'd2);
		send_element(1'b0, 8'h80, 32'h0000_0001, 32'hFFFF_FFFF, 24'd100);
		drain();
		// Saturation of the cache with a huge gradient at rho zero.
		write_reg(REG_FORGET_FACTOR, 32'd0);
		write_reg(REG_STABILIZER, 32'd0);
		write_reg(REG_BASE_RATE, 32'hFFFF_FFFF);
		send_element(1'b0, 8'd7, 32'h8000_0000, 32'h8000_0001, 24'd0);
		send_element(1'b0, 8'd8, 32'h7FFF_FFFF, 32'h7FFF_0000, 24'd0);
		// A zero gradient with zero epsilon takes the root of zero.
		send_element(1'b1, 8'd9, 32'd0, 32'h0000_1000, 24'd0);
		send_element(1'b1, 8'd10, 32'hFFFF_FFFF, 32'h7FFF_FFF0, 24'd0);
		send_element(1'b1, 8'd11, 32'h0000_0001, 32'h8000_0010, 24'd0);
		drain();
	endtask

	task automatic test_settings();
		write_reg(REG_FORGET_FACTOR, 32'hFFFF);
		write_reg(REG_RATE_DECAY, 32'hFFFF_FFFF);
		write_reg(REG_STABILIZER, 32'hFFFF_FFFF);
		send_random(150, 1'b0);
		drain();
		write_reg(REG_RATE_DECAY, 32'd1 << 20);
		write_reg(REG_BASE_RATE, 32'd1 << 24);
		write_reg(REG_STABILIZER, 32'd1);
		write_reg(REG_FORGET_FACTOR, 32'd32768);
		send_random(300, 1'b1);
		drain();
		write_reg(REG_BASE_RATE, $urandom);
		write_reg(REG_RATE_DECAY, $urandom_range(0, 1) ? 32'd0 : $urandom);
		write_reg(REG_STABILIZER, $urandom);
		write_reg(REG_FORGET_FACTOR, $urandom);
		send_random(500, 1'b0);
		drain();
	endtask

	task automatic test_full_rate();
		write_reg(REG_BASE_RATE, 32'd16777);
		write_reg(REG_RATE_DECAY, 32'd0);
		write_reg(REG_STABILIZER, 32'd1);
		write_reg(REG_FORGET_FACTOR, 32'd58982);
		send_random(300, 1'b1);
		src_gaps_on = 1'b0;
		sink_stall_on = 1'b0;
		send_random(400, 1'b1);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 2*CH; i++) model_cache[i] = '0;
		lr = BASE_RATE_RST;
		decay = RATE_DECAY_RST;
		eps = STABILIZER_RST;
		rho = FORGET_FACTOR_RST;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_settings();
		test_full_rate();
		if (!failed && pending_updates.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
